// ===== hw/rtl/dwsu_pkg.sv =====
// ----------------------------------------------------------------------------
// DAQ word stream unpacker package
// Shared types, codes and the word CRC function.
// ----------------------------------------------------------------------------
package dwsu_pkg;

   localparam int unsigned MaxLinks        = 64;
   localparam int unsigned ChannelsPerLink = 40;
   localparam int unsigned MapBits         = 40;
   localparam int unsigned CountLanes      = 4;
   localparam int unsigned CountRows       = MaxLinks / CountLanes;
   localparam int unsigned CountWidth      = 6;

   localparam logic [3:0] CLS_HDR0      = 4'd0;
   localparam logic [3:0] CLS_HDR1      = 4'd1;
   localparam logic [3:0] CLS_COUNTS    = 4'd2;
   localparam logic [3:0] CLS_LINK_HDR  = 4'd3;
   localparam logic [3:0] CLS_MAP       = 4'd4;
   localparam logic [3:0] CLS_CHIP_HDR  = 4'd5;
   localparam logic [3:0] CLS_COMMON    = 4'd6;
   localparam logic [3:0] CLS_SAMPLE    = 4'd7;
   localparam logic [3:0] CLS_LINK_CRC  = 4'd8;
   localparam logic [3:0] CLS_FRAME_CRC = 4'd9;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_VERSION   = 3'd1;
   localparam logic [2:0] ERR_LINK_CRC  = 3'd2;
   localparam logic [2:0] ERR_FRAME_CRC = 3'd3;
   localparam logic [2:0] ERR_TRUNCATED = 3'd4;

   localparam logic [3:0] ChipRevReset = 4'd2;
   localparam logic [2:0] CSR_CHIP_REV = 3'd0;

   typedef struct packed {
      logic [31:0] data_word;
      logic        last_word;
   } item_type;

   typedef struct packed {
      logic [3:0]  word_class;
      logic [5:0]  link_index;
      logic [5:0]  channel_number;
      logic [12:0] electronic_id;
      logic [31:0] sample_word;
      logic [2:0]  error_code;
      logic        frame_done;
      logic [7:0]  board_id;
      logic [11:0] bunch_id;
   } result_type;

   function automatic logic [31:0] crc32_word(input logic [31:0] crc, input logic [31:0] w);
      logic [31:0] c;
      c = crc ^ w;
      for (int i = 0; i < 32; i++) begin
         c = (c >> 1) ^ (32'hEDB88320 & {32{c[0]}});
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/dwsu_if.sv =====
// ----------------------------------------------------------------------------
// DAQ word stream unpacker channels
// Valid/ready channels for incoming words and labeled result items.
// ----------------------------------------------------------------------------
interface dwsu_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_word;
   logic        last_word;

   modport source (output valid, output data_word, output last_word, input ready);
   modport sink (input valid, input data_word, input last_word, output ready);
endinterface

interface dwsu_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  word_class;
   logic [5:0]  link_index;
   logic [5:0]  channel_number;
   logic [12:0] electronic_id;
   logic [31:0] sample_word;
   logic [2:0]  error_code;
   logic        frame_done;
   logic [7:0]  board_id;
   logic [11:0] bunch_id;

   modport source (output valid, output word_class, output link_index,
                   output channel_number, output electronic_id, output sample_word,
                   output error_code, output frame_done, output board_id,
                   output bunch_id, input ready);
   modport sink (input valid, input word_class, input link_index,
                 input channel_number, input electronic_id, input sample_word,
                 input error_code, input frame_done, input board_id,
                 input bunch_id, output ready);
endinterface

// ===== hw/rtl/dwsu_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dwsu_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/dwsu_front.sv =====
// ----------------------------------------------------------------------------
// DAQ word stream unpacker front end
// Accepts words and holds them in a two-entry queue for the parser.
// ----------------------------------------------------------------------------
module dwsu_front
   import dwsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   dwsu_req_if.sink    req_chan,
   output item_type    head_item,
   output logic        head_valid,
   input  logic        head_pop
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign req_chan.ready = (count_ff != 2'd2);
   assign push           = req_chan.valid && req_chan.ready;
   assign head_valid     = (count_ff != 2'd0);
   assign head_item      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ head_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, head_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{data_word: req_chan.data_word,
                                  last_word: req_chan.last_word};
      end
   end

endmodule

// ===== hw/rtl/dwsu_back.sv =====
// ----------------------------------------------------------------------------
// DAQ word stream unpacker back end
// Frame parser, CRC checks, channel search and the result register.
// ----------------------------------------------------------------------------
module dwsu_back
   import dwsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  item_type    head_item,
   input  logic        head_valid,
   output logic        head_pop,
   input  logic [3:0]  chip_rev,
   dwsu_rsp_if.source  rsp_chan
);

   localparam logic [2:0] PH_HDR0   = 3'd0;
   localparam logic [2:0] PH_HDR1   = 3'd1;
   localparam logic [2:0] PH_COUNTS = 3'd2;
   localparam logic [2:0] PH_LHDR   = 3'd3;
   localparam logic [2:0] PH_MAP    = 3'd4;
   localparam logic [2:0] PH_CHAN   = 3'd5;
   localparam logic [2:0] PH_FCRC   = 3'd6;

   localparam int unsigned RowBits  = $clog2(CountRows);
   localparam int unsigned SearchLim =
      (ChannelsPerLink < MapBits) ? ChannelsPerLink : MapBits;

   logic [2:0]          phase_ff, phase_in;
   logic [5:0]          link_total_ff, link_total_in;
   logic [5:0]          link_cur_ff, link_cur_in;
   logic [MapBits-1:0]  mask_ff, mask_in;
   logic [5:0]          chan_cur_ff, chan_cur_in;
   logic [5:0]          chan_left_ff, chan_left_in;
   logic [31:0]         frame_crc_ff, frame_crc_in;
   logic [31:0]         link_crc_ff, link_crc_in;
   logic [7:0]          board_ff, board_in;
   logic [11:0]         bunch_ff, bunch_in;
   logic                rsp_valid_ff;
   result_type          rsp_ff, rsp_in;

   logic                      cnt_wr_en;
   logic [CountLanes*CountWidth-1:0] cnt_wr_data;
   logic [CountLanes*CountWidth-1:0] cnt_rd_data;
   logic [CountWidth-1:0]     cnt_lane;

   logic        fire;
   logic [31:0] w;
   logic [5:0]  cm_chan;
   logic [5:0]  found_ch;
   logic        found;
   logic [5:0]  ch;
   logic [6:0]  link_next;
   logic [6:0]  counts_next;
   logic [5:0]  left_dec;
   logic [12:0] eid_prod;

   assign fire     = head_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign head_pop = fire;
   assign w        = head_item.data_word;
   assign cm_chan  = (chip_rev == ChipRevReset) ? 6'd19 : 6'd1;

   dwsu_ram #(
      .WIDTH(CountLanes * CountWidth),
      .DEPTH(CountRows)
   ) u_count_ram (
      .clock  (clock),
      .wr_en  (cnt_wr_en),
      .wr_addr(link_cur_ff[RowBits+1:2]),
      .wr_data(cnt_wr_data),
      .rd_addr(link_cur_ff[RowBits+1:2]),
      .rd_data(cnt_rd_data)
   );

   assign cnt_wr_data = {w[29:24], w[21:16], w[13:8], w[5:0]};
   assign cnt_lane    = cnt_rd_data[link_cur_ff[1:0]*CountWidth +: CountWidth];

   always_comb begin
      found_ch = 6'd0;
      found    = 1'b0;
      for (int i = SearchLim - 1; i >= 0; i--) begin
         if (mask_ff[i] && (6'(i) >= chan_cur_ff)) begin
            found_ch = 6'(i);
            found    = 1'b1;
         end
      end
   end

   assign ch        = found ? found_ch :
                      ((chan_cur_ff > 6'(SearchLim)) ? chan_cur_ff : 6'(SearchLim));
   assign link_next = {1'b0, link_cur_ff} + 7'd1;
   assign counts_next = {1'b0, link_cur_ff} + 7'd4;
   assign left_dec  = (chan_left_ff != 6'd0) ? chan_left_ff - 6'd1 : 6'd0;
   assign eid_prod  = ({7'd0, link_cur_ff} * 13'd100) + {7'd0, ch};

   always_comb begin
      phase_in      = phase_ff;
      link_total_in = link_total_ff;
      link_cur_in   = link_cur_ff;
      mask_in       = mask_ff;
      chan_cur_in   = chan_cur_ff;
      chan_left_in  = chan_left_ff;
      frame_crc_in  = frame_crc_ff;
      link_crc_in   = link_crc_ff;
      board_in      = board_ff;
      bunch_in      = bunch_ff;
      cnt_wr_en     = 1'b0;
      rsp_in        = '0;

      unique case (phase_ff)
         PH_HDR1: begin
            rsp_in.word_class = CLS_HDR1;
            frame_crc_in = crc32_word(frame_crc_ff, w);
            bunch_in     = w[31:20];
            link_cur_in  = 6'd0;
            phase_in     = (link_total_ff != 6'd0) ? PH_COUNTS : PH_FCRC;
         end
         PH_COUNTS: begin
            rsp_in.word_class = CLS_COUNTS;
            rsp_in.link_index = link_cur_ff;
            frame_crc_in = crc32_word(frame_crc_ff, w);
            cnt_wr_en    = fire;
            if (counts_next >= {1'b0, link_total_ff}) begin
               link_cur_in = 6'd0;
               phase_in    = PH_LHDR;
            end else begin
               link_cur_in = counts_next[5:0];
            end
         end
         PH_LHDR: begin
            rsp_in.word_class = CLS_LINK_HDR;
            rsp_in.link_index = link_cur_ff;
            frame_crc_in = crc32_word(frame_crc_ff, w);
            link_crc_in  = crc32_word(32'hFFFFFFFF, w);
            mask_in      = {w[7:0], 32'd0};
            phase_in     = PH_MAP;
         end
         PH_MAP: begin
            rsp_in.word_class = CLS_MAP;
            rsp_in.link_index = link_cur_ff;
            frame_crc_in  = crc32_word(frame_crc_ff, w);
            link_crc_in   = crc32_word(link_crc_ff, w);
            mask_in[31:0] = w;
            chan_left_in  = cnt_lane;
            chan_cur_in   = 6'd0;
            if (cnt_lane == 6'd0) begin
               link_cur_in = link_next[5:0];
               phase_in    = (link_next >= {1'b0, link_total_ff}) ? PH_FCRC : PH_LHDR;
            end else begin
               phase_in = PH_CHAN;
            end
         end
         PH_CHAN: begin
            rsp_in.link_index     = link_cur_ff;
            rsp_in.channel_number = ch;
            frame_crc_in = crc32_word(frame_crc_ff, w);
            chan_cur_in  = (ch < 6'd63) ? ch + 6'd1 : 6'd63;
            if (ch == 6'd0) begin
               rsp_in.word_class = CLS_CHIP_HDR;
               link_crc_in = crc32_word(link_crc_ff, w);
            end else if (ch == cm_chan) begin
               rsp_in.word_class = CLS_COMMON;
               link_crc_in = crc32_word(link_crc_ff, w);
            end else if (ch == 6'd39) begin
               rsp_in.word_class = CLS_LINK_CRC;
               if (~link_crc_ff != w) begin
                  rsp_in.error_code = ERR_LINK_CRC;
               end
            end else begin
               rsp_in.word_class    = CLS_SAMPLE;
               link_crc_in          = crc32_word(link_crc_ff, w);
               rsp_in.electronic_id = eid_prod;
               rsp_in.sample_word   = w;
            end
            chan_left_in = left_dec;
            if (rsp_in.error_code == ERR_NONE && left_dec == 6'd0) begin
               link_cur_in = link_next[5:0];
               phase_in    = (link_next >= {1'b0, link_total_ff}) ? PH_FCRC : PH_LHDR;
            end
         end
         PH_FCRC: begin
            rsp_in.word_class = CLS_FRAME_CRC;
            rsp_in.frame_done = 1'b1;
            if (~frame_crc_ff != w) begin
               rsp_in.error_code = ERR_FRAME_CRC;
            end
            phase_in = PH_HDR0;
         end
         default: begin
            rsp_in.word_class = CLS_HDR0;
            frame_crc_in = crc32_word(32'hFFFFFFFF, w);
            board_in     = w[26:19];
            bunch_in     = 12'd0;
            if (w[30:27] != 4'd1) begin
               rsp_in.error_code = ERR_VERSION;
               phase_in          = PH_HDR0;
            end else begin
               link_total_in = w[18:13];
               phase_in      = PH_HDR1;
            end
         end
      endcase

      if (rsp_in.error_code == ERR_NONE && head_item.last_word && phase_ff != PH_FCRC) begin
         rsp_in.error_code = ERR_TRUNCATED;
      end
      if (rsp_in.error_code != ERR_NONE) begin
         rsp_in.frame_done = 1'b1;
         phase_in          = PH_HDR0;
      end
      rsp_in.board_id = board_in;
      rsp_in.bunch_id = bunch_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HDR0;
         link_total_ff <= 6'd0;
         link_cur_ff   <= 6'd0;
         mask_ff       <= '0;
         chan_cur_ff   <= 6'd0;
         chan_left_ff  <= 6'd0;
         frame_crc_ff  <= 32'hFFFFFFFF;
         link_crc_ff   <= 32'hFFFFFFFF;
         board_ff      <= 8'd0;
         bunch_ff      <= 12'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (fire) begin
            phase_ff      <= phase_in;
            link_total_ff <= link_total_in;
            link_cur_ff   <= link_cur_in;
            mask_ff       <= mask_in;
            chan_cur_ff   <= chan_cur_in;
            chan_left_ff  <= chan_left_in;
            frame_crc_ff  <= frame_crc_in;
            link_crc_ff   <= link_crc_in;
            board_ff      <= board_in;
            bunch_ff      <= bunch_in;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.word_class     = rsp_ff.word_class;
   assign rsp_chan.link_index     = rsp_ff.link_index;
   assign rsp_chan.channel_number = rsp_ff.channel_number;
   assign rsp_chan.electronic_id  = rsp_ff.electronic_id;
   assign rsp_chan.sample_word    = rsp_ff.sample_word;
   assign rsp_chan.error_code     = rsp_ff.error_code;
   assign rsp_chan.frame_done     = rsp_ff.frame_done;
   assign rsp_chan.board_id       = rsp_ff.board_id;
   assign rsp_chan.bunch_id       = rsp_ff.bunch_id;

`ifndef SYNTHESIS
   a_error_ends_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.error_code != ERR_NONE |-> rsp_ff.frame_done)
      else $error("error item without frame_done");

   a_error_resets_phase: assert property (@(posedge clock) disable iff (reset)
      fire && rsp_in.error_code != ERR_NONE |=> phase_ff == PH_HDR0)
      else $error("parser did not return to frame header after error");

   a_frame_crc_resets_phase: assert property (@(posedge clock) disable iff (reset)
      fire && phase_ff == PH_FCRC |=> phase_ff == PH_HDR0)
      else $error("parser did not return to frame header after frame CRC");

   a_link_in_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_LHDR || phase_ff == PH_MAP || phase_ff == PH_CHAN
      |-> link_cur_ff < link_total_ff)
      else $error("link index beyond link count");
`endif

endmodule

// ===== hw/rtl/daq_word_stream_unpacker.sv =====
// ----------------------------------------------------------------------------
// DAQ word stream unpacker
// Labels each word of a readout frame and checks link and frame CRCs.
// ----------------------------------------------------------------------------
// Path: an accepted word passes through the input queue and then through the
// parser into the result register.
// Throughput: one word per cycle; the parser handles one word per cycle unless stalled by the result channel.
// Reset: synchronous and active high; the parser waits for a frame header,
// the queue and result register are empty and the chip revision returns to 2.
module daq_word_stream_unpacker
   import dwsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   dwsu_req_if.sink    req_chan,
   dwsu_rsp_if.source  rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [3:0] chip_rev_ff, chip_rev_in;
   logic       csr_hit;
   item_type   head_item;
   logic       head_valid;
   logic       head_pop;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[1:0] == 2'b00) &&
                       ({2'b00, csr_paddr[2]} == CSR_CHIP_REV);
   assign csr_prdata = csr_hit ? {28'd0, chip_rev_ff} : 32'd0;

   always_comb begin
      chip_rev_in = chip_rev_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         chip_rev_in = csr_pwdata[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chip_rev_ff <= ChipRevReset;
      end else begin
         chip_rev_ff <= chip_rev_in;
      end
   end

   dwsu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .head_item (head_item),
      .head_valid(head_valid),
      .head_pop  (head_pop)
   );

   dwsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_item  (head_item),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .chip_rev   (chip_rev_ff),
      .rsp_chan   (rsp_chan)
   );

endmodule
